/* design/mrda_pkg.sv */
// Shared types, widths and constants for the mixed-radix duration accumulator.
// No dependencies; every module of the block imports this package.
package mrda_pkg;

	// Width of the held year count; years wrap modulo 2**YEAR_BITS (range 8..48)
	localparam int YEAR_BITS = 32;

	// Port field widths
	localparam int OP_W    = 2;
	localparam int YEARS_W = 32;
	localparam int DAY_W   = 9;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int TSEC_W  = 57;
	localparam int TDAY_W  = 41;
	localparam int HMS_W   = 17;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 2'd2;

	// Radix constants
	localparam int DAYS_PER_YEAR = 365;
	localparam int HOURS_PER_DAY = 24;
	localparam int UNITS_60      = 60;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_DAY   = 86400;

	// One duration in mixed-radix form
	typedef struct packed {
		logic [YEAR_BITS-1:0] years;
		logic [DAY_W-1:0]     days;
		logic [HOUR_W-1:0]    hours;
		logic [MIN_W-1:0]     minutes;
		logic [SEC_W-1:0]     seconds;
	} dur_t;

endpackage

/* design/mrda_step.sv */
// Held duration register and the load / add-with-carry / subtract-with-borrow update.
// Depends on mrda_pkg (dur_t, op codes, radix constants).
module mrda_step
	import mrda_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd,
	input  logic [OP_W-1:0] op,
	input  dur_t            operand,
	output dur_t            held
);

	dur_t held_q;
	dur_t sum;
	dur_t dif;
	dur_t nxt;

	logic [6:0] s_sum, m_sum;
	logic [5:0] h_sum;
	logic [9:0] d_sum;
	logic       c_s, c_m, c_h, c_d;

	logic [6:0] need_m;
	logic [5:0] need_h;
	logic [9:0] need_d;
	logic       b_s, b_m, b_h, b_d;

	// Add with carries, seconds up to years
	always_comb begin
		s_sum = 7'(held_q.seconds) + 7'(operand.seconds);
		c_s   = s_sum >= 7'(UNITS_60);
		sum.seconds = c_s ? SEC_W'(s_sum - 7'(UNITS_60)) : SEC_W'(s_sum);

		m_sum = 7'(held_q.minutes) + 7'(operand.minutes) + 7'(c_s);
		c_m   = m_sum >= 7'(UNITS_60);
		sum.minutes = c_m ? MIN_W'(m_sum - 7'(UNITS_60)) : MIN_W'(m_sum);

		h_sum = 6'(held_q.hours) + 6'(operand.hours) + 6'(c_m);
		c_h   = h_sum >= 6'(HOURS_PER_DAY);
		sum.hours = c_h ? HOUR_W'(h_sum - 6'(HOURS_PER_DAY)) : HOUR_W'(h_sum);

		d_sum = 10'(held_q.days) + 10'(operand.days) + 10'(c_h);
		c_d   = d_sum >= 10'(DAYS_PER_YEAR);
		sum.days = c_d ? DAY_W'(d_sum - 10'(DAYS_PER_YEAR)) : DAY_W'(d_sum);

		sum.years = held_q.years + operand.years + YEAR_BITS'(c_d);
	end

	// Subtract with borrows
	always_comb begin
		b_s = held_q.seconds < operand.seconds;
		dif.seconds = b_s ? SEC_W'(7'(held_q.seconds) + 7'(UNITS_60) - 7'(operand.seconds))
		                  : SEC_W'(held_q.seconds - operand.seconds);

		need_m = 7'(operand.minutes) + 7'(b_s);
		b_m    = 7'(held_q.minutes) < need_m;
		dif.minutes = b_m ? MIN_W'(7'(held_q.minutes) + 7'(UNITS_60) - need_m)
		                  : MIN_W'(7'(held_q.minutes) - need_m);

		need_h = 6'(operand.hours) + 6'(b_m);
		b_h    = 6'(held_q.hours) < need_h;
		dif.hours = b_h ? HOUR_W'(6'(held_q.hours) + 6'(HOURS_PER_DAY) - need_h)
		                : HOUR_W'(6'(held_q.hours) - need_h);

		need_d = 10'(operand.days) + 10'(b_h);
		b_d    = 10'(held_q.days) < need_d;
		dif.days = b_d ? DAY_W'(10'(held_q.days) + 10'(DAYS_PER_YEAR) - need_d)
		               : DAY_W'(10'(held_q.days) - need_d);

		dif.years = held_q.years - operand.years - YEAR_BITS'(b_d);
	end

	always_comb begin
		case (op)
			OP_LOAD: nxt = operand;
			OP_ADD:  nxt = sum;
			OP_SUB:  nxt = dif;
			default: nxt = held_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (upd) begin
			held_q <= nxt;
		end
	end

	assign held = held_q;

endmodule

/* design/mrda_totals.sv */
// Two-stage totals pipeline: days total and h/m/s seconds, then seconds total.
// Depends on mrda_pkg (dur_t, widths, radix constants).
module mrda_totals
	import mrda_pkg::*;
(
	input  logic                       clk,
	input  logic                       adv,
	input  dur_t                       held,
	output logic signed [YEARS_W-1:0]  now_years,
	output logic        [DAY_W-1:0]    now_days,
	output logic        [HOUR_W-1:0]   now_hours,
	output logic        [MIN_W-1:0]    now_minutes,
	output logic        [SEC_W-1:0]    now_seconds,
	output logic signed [TSEC_W-1:0]   total_seconds,
	output logic signed [TDAY_W-1:0]   total_days
);

	logic [TSEC_W-1:0]  ys_ext;
	logic [TSEC_W-1:0]  tday_s3;
	logic [HMS_W-1:0]   hms_s3;
	logic [YEARS_W-1:0] years_s3;
	logic [DAY_W-1:0]   days_s3;
	logic [HOUR_W-1:0]  hours_s3;
	logic [MIN_W-1:0]   minutes_s3;
	logic [SEC_W-1:0]   seconds_s3;

	// sign-extended year count, wrapped to the seconds total width
	assign ys_ext = TSEC_W'($signed(held.years));

	// years*365 + days kept at full seconds width so *86400 wraps correctly later
	always_ff @(posedge clk) begin
		if (adv) begin
			tday_s3    <= ys_ext * TSEC_W'(DAYS_PER_YEAR) + TSEC_W'(held.days);
			hms_s3     <= HMS_W'(held.hours) * HMS_W'(SEC_PER_HOUR)
			            + HMS_W'(held.minutes) * HMS_W'(UNITS_60)
			            + HMS_W'(held.seconds);
			years_s3   <= YEARS_W'($signed(held.years));
			days_s3    <= held.days;
			hours_s3   <= held.hours;
			minutes_s3 <= held.minutes;
			seconds_s3 <= held.seconds;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_seconds <= $signed(tday_s3 * TSEC_W'(SEC_PER_DAY) + TSEC_W'(hms_s3));
			total_days    <= $signed(tday_s3[TDAY_W-1:0]);
			now_years     <= $signed(years_s3);
			now_days      <= days_s3;
			now_hours     <= hours_s3;
			now_minutes   <= minutes_s3;
			now_seconds   <= seconds_s3;
		end
	end

endmodule

/* design/mixed_radix_duration_accumulator_top.sv */
// Mixed-radix duration accumulator, top level.
// Throughput: one request per cycle unless a stalled result holds the pipeline; the
// held-value update is a combinational carry loop into a single register.
// Reset: arst_n (async, active low) clears the held duration to zero and drops all valids.
// Depends on mrda_pkg, mrda_step, mrda_totals.
module mixed_radix_duration_accumulator_top
	import mrda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	// request channel
	input  logic                      op_valid,
	output logic                      op_stall,
	input  logic [OP_W-1:0]           op,
	input  logic signed [YEARS_W-1:0] operand_years,
	input  logic [DAY_W-1:0]          operand_days,
	input  logic [HOUR_W-1:0]         operand_hours,
	input  logic [MIN_W-1:0]          operand_minutes,
	input  logic [SEC_W-1:0]          operand_seconds,

	// result channel
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [YEARS_W-1:0] now_years,
	output logic [DAY_W-1:0]          now_days,
	output logic [HOUR_W-1:0]         now_hours,
	output logic [MIN_W-1:0]          now_minutes,
	output logic [SEC_W-1:0]          now_seconds,
	output logic signed [TSEC_W-1:0]  total_seconds,
	output logic signed [TDAY_W-1:0]  total_days
);

	// Year operand is sign-extended or truncated to the held width
	localparam int EXT_W = (YEAR_BITS > YEARS_W) ? YEAR_BITS : YEARS_W;

	// Pipeline:
	//   s1     : request register, operand fields saturated to their legal range
	//   held_q : updated from s1 (load/add/sub); doubles as stage 2
	//   s3     : days total and h/m/s seconds
	//   s4     : output register (seconds total)
	// Everything moves together on adv; the only hold-off is a stalled result.

	logic       adv;
	logic       v1_q, v2_q, v3_q, v4_q;

	logic [OP_W-1:0]  op_s1;
	dur_t             opd_s1;
	logic [EXT_W-1:0] oy_ext;
	dur_t             held;

	assign adv      = !(v4_q && res_stall);
	assign op_stall = !adv;
	assign oy_ext   = EXT_W'(operand_years);

	// capture request, saturating out-of-range parts
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1        <= op;
			opd_s1.years <= oy_ext[YEAR_BITS-1:0];
			opd_s1.days  <= (operand_days > DAY_W'(DAYS_PER_YEAR - 1))
			              ? DAY_W'(DAYS_PER_YEAR - 1) : operand_days;
			opd_s1.hours <= (operand_hours > HOUR_W'(HOURS_PER_DAY - 1))
			              ? HOUR_W'(HOURS_PER_DAY - 1) : operand_hours;
			opd_s1.minutes <= (operand_minutes > MIN_W'(UNITS_60 - 1))
			                ? MIN_W'(UNITS_60 - 1) : operand_minutes;
			opd_s1.seconds <= (operand_seconds > SEC_W'(UNITS_60 - 1))
			                ? SEC_W'(UNITS_60 - 1) : operand_seconds;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else if (adv) begin
			v1_q <= op_valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
		end
	end

	// held value moves exactly once per request, when it leaves s1
	mrda_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (adv && v1_q),
		.op      (op_s1),
		.operand (opd_s1),
		.held    (held)
	);

	// held_q is sampled by s3 on the same edge that may overwrite it,
	// so s3 always sees the value left by the request in stage 2
	mrda_totals u_totals (
		.clk           (clk),
		.adv           (adv),
		.held          (held),
		.now_years     (now_years),
		.now_days      (now_days),
		.now_hours     (now_hours),
		.now_minutes   (now_minutes),
		.now_seconds   (now_seconds),
		.total_seconds (total_seconds),
		.total_days    (total_days)
	);

	assign res_valid = v4_q;

endmodule

/* tb/sv/tb_mixed_radix_duration_accumulator_top.sv */
// Self-checking testbench for mixed_radix_duration_accumulator_top: directed corner requests
// and random load/add/subtract traffic, checked against an in-bench duration predictor.
// Depends on mrda_pkg and the RTL of the block; needs no files or arguments.
module tb_mixed_radix_duration_accumulator_top;
	import mrda_pkg::*;

	// Unused opcode: the block must hold its value and still report it
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam longint SEC_PER_YEAR  = longint'(DAYS_PER_YEAR) * SEC_PER_DAY;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam int     DRAIN_CYCLES  = 10;   // margin beyond the result latency
	localparam int     RANDOM_COUNT  = 1650;
	localparam int     REPORT_LIMIT  = 10;

	// Sender-side request, with a flag that holds it back until the block has drained
	typedef struct {
		logic [OP_W-1:0]           op;
		logic signed [YEARS_W-1:0] years;
		logic [DAY_W-1:0]          days;
		logic [HOUR_W-1:0]         hours;
		logic [MIN_W-1:0]          minutes;
		logic [SEC_W-1:0]          seconds;
		bit                        drain_first;
	} duration_req_t;

	// Everything the result port reports for one request
	typedef struct {
		logic [YEARS_W-1:0] years;
		logic [DAY_W-1:0]   days;
		logic [HOUR_W-1:0]  hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [TSEC_W-1:0]  tsec;
		logic [TDAY_W-1:0]  tday;
	} duration_snapshot_t;

	typedef enum int {RX_FLOW, RX_CHOPPY, RX_LONG_STALLS} rx_mode_t;

	// ------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic                      clk             = 1'b0;
	logic                      arst_n          = 1'b0;
	logic                      op_valid        = 1'b0;
	logic                      op_stall;
	logic [OP_W-1:0]           op              = '0;
	logic signed [YEARS_W-1:0] operand_years   = '0;
	logic [DAY_W-1:0]          operand_days    = '0;
	logic [HOUR_W-1:0]         operand_hours   = '0;
	logic [MIN_W-1:0]          operand_minutes = '0;
	logic [SEC_W-1:0]          operand_seconds = '0;
	logic                      res_valid;
	logic                      res_stall       = 1'b0;
	logic signed [YEARS_W-1:0] now_years;
	logic [DAY_W-1:0]          now_days;
	logic [HOUR_W-1:0]         now_hours;
	logic [MIN_W-1:0]          now_minutes;
	logic [SEC_W-1:0]          now_seconds;
	logic signed [TSEC_W-1:0]  total_seconds;
	logic signed [TDAY_W-1:0]  total_days;

	mixed_radix_duration_accumulator_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.op_valid        (op_valid),
		.op_stall        (op_stall),
		.op              (op),
		.operand_years   (operand_years),
		.operand_days    (operand_days),
		.operand_hours   (operand_hours),
		.operand_minutes (operand_minutes),
		.operand_seconds (operand_seconds),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.now_years       (now_years),
		.now_days        (now_days),
		.now_hours       (now_hours),
		.now_minutes     (now_minutes),
		.now_seconds     (now_seconds),
		.total_seconds   (total_seconds),
		.total_days      (total_days)
	);

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	duration_req_t      pending_requests[$];
	duration_snapshot_t expected_durations[$];
	int                 mismatch_count = 0;
	int                 cycle_count    = 0;

	// Predictor copy of the held duration (reset value is zero)
	logic signed [YEAR_BITS-1:0] acc_years   = '0;
	int unsigned                 acc_days    = 0;
	int unsigned                 acc_hours   = 0;
	int unsigned                 acc_minutes = 0;
	int unsigned                 acc_seconds = 0;

	// Handshake bookkeeping between the posedge monitor and the negedge driver
	bit req_taken = 1'b0;   // set at the edge that accepted the presented request
	bit slot_busy = 1'b0;   // a request is on the port and not yet taken
	int tx_burst_left = 0;
	int tx_gap_left   = 0;
	rx_mode_t rx_mode = RX_FLOW;
	int rx_mode_left  = 0;
	int rx_stall_run  = 0;

	// Clock: 10 time units
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: advances the held duration by one request and returns
	// what the result port should show afterwards.
	// ------------------------------------------------------------------
	function automatic duration_snapshot_t step_duration(
		input logic [OP_W-1:0] req_op,
		input logic signed [YEARS_W-1:0] req_years,
		input logic [DAY_W-1:0] req_days, input logic [HOUR_W-1:0] req_hours,
		input logic [MIN_W-1:0] req_minutes, input logic [SEC_W-1:0] req_seconds);
		logic signed [YEAR_BITS-1:0] oy;
		int unsigned od, oh, om, os, c, need, s, m, h, d;
		longint ys, tsec, tday;
		duration_snapshot_t snap;
		// signed assignment: sign-extends or truncates to the held year width
		oy = req_years;
		// out-of-range parts saturate before use
		od = (req_days    > DAYS_PER_YEAR - 1) ? DAYS_PER_YEAR - 1 : req_days;
		oh = (req_hours   > HOURS_PER_DAY - 1) ? HOURS_PER_DAY - 1 : req_hours;
		om = (req_minutes > UNITS_60 - 1)      ? UNITS_60 - 1      : req_minutes;
		os = (req_seconds > UNITS_60 - 1)      ? UNITS_60 - 1      : req_seconds;
		case (req_op)
			OP_LOAD: begin
				acc_years   = oy;
				acc_days    = od;
				acc_hours   = oh;
				acc_minutes = om;
				acc_seconds = os;
			end
			OP_ADD: begin
				s = acc_seconds + os;
				c = (s >= UNITS_60);
				if (c) s -= UNITS_60;
				m = acc_minutes + om + c;
				c = (m >= UNITS_60);
				if (c) m -= UNITS_60;
				h = acc_hours + oh + c;
				c = (h >= HOURS_PER_DAY);
				if (c) h -= HOURS_PER_DAY;
				d = acc_days + od + c;
				c = (d >= DAYS_PER_YEAR);
				if (c) d -= DAYS_PER_YEAR;
				acc_years   = acc_years + oy + c;
				acc_days    = d;
				acc_hours   = h;
				acc_minutes = m;
				acc_seconds = s;
			end
			OP_SUB: begin
				c = (acc_seconds < os);
				s = acc_seconds + (c ? UNITS_60 : 0) - os;
				need = om + c;
				c = (acc_minutes < need);
				m = acc_minutes + (c ? UNITS_60 : 0) - need;
				need = oh + c;
				c = (acc_hours < need);
				h = acc_hours + (c ? HOURS_PER_DAY : 0) - need;
				need = od + c;
				c = (acc_days < need);
				d = acc_days + (c ? DAYS_PER_YEAR : 0) - need;
				acc_years   = acc_years - oy - c;
				acc_days    = d;
				acc_hours   = h;
				acc_minutes = m;
				acc_seconds = s;
			end
			default: ;   // unused opcode: hold
		endcase
		ys   = acc_years;
		tsec = ys * SEC_PER_YEAR + longint'(acc_days) * SEC_PER_DAY
			+ longint'(acc_hours) * SEC_PER_HOUR + longint'(acc_minutes) * UNITS_60
			+ longint'(acc_seconds);
		tday = ys * DAYS_PER_YEAR + longint'(acc_days);
		snap.years   = ys[YEARS_W-1:0];
		snap.days    = acc_days[DAY_W-1:0];
		snap.hours   = acc_hours[HOUR_W-1:0];
		snap.minutes = acc_minutes[MIN_W-1:0];
		snap.seconds = acc_seconds[SEC_W-1:0];
		snap.tsec    = tsec[TSEC_W-1:0];
		snap.tday    = tday[TDAY_W-1:0];
		return snap;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_request(input logic [OP_W-1:0] r_op, input int r_years,
		input int r_days, input int r_hours, input int r_minutes, input int r_seconds,
		input bit r_drain = 1'b0);
		duration_req_t r;
		r.op          = r_op;
		r.years       = r_years;
		r.days        = r_days[DAY_W-1:0];
		r.hours       = r_hours[HOUR_W-1:0];
		r.minutes     = r_minutes[MIN_W-1:0];
		r.seconds     = r_seconds[SEC_W-1:0];
		r.drain_first = r_drain;
		pending_requests.push_back(r);
	endtask

	// Mostly in-range parts; one in ten spans the whole field width
	function automatic int pick_part(input int max_legal, input int width);
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, (1 << width) - 1));
		return int'($urandom_range(0, max_legal));
	endfunction

	function automatic int pick_years();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return int'($urandom_range(0, 6)) - 3;
			5, 6:          return int'($urandom);
			7: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh7fff_ffff;
					1:       return 32'sh8000_0000;
					2:       return 0;
					default: return -1;
				endcase
			end
			default:       return int'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic queue_random_request(input bit r_drain);
		logic [OP_W-1:0] r_op;
		int pick;
		pick = $urandom_range(0, 99);
		// loads are kept rare so that long carry/borrow chains build up
		if (pick < 12)      r_op = OP_LOAD;
		else if (pick < 53) r_op = OP_ADD;
		else if (pick < 94) r_op = OP_SUB;
		else                r_op = OP_NOP;
		queue_request(r_op, pick_years(), pick_part(DAYS_PER_YEAR - 1, DAY_W),
			pick_part(HOURS_PER_DAY - 1, HOUR_W), pick_part(UNITS_60 - 1, MIN_W),
			pick_part(UNITS_60 - 1, SEC_W), r_drain);
	endtask

	// ------------------------------------------------------------------
	// Driver: presents requests at the falling edge, holds a request
	// steady until taken, and works in bursts separated by random gaps.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		duration_req_t r;
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				slot_busy = 1'b0;
			end
			if (!slot_busy) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					op_valid <= 1'b0;
				end else if (pending_requests.size() == 0 ||
						(pending_requests[0].drain_first && expected_durations.size() != 0)) begin
					// nothing to send, or holding off until every result is back
					op_valid <= 1'b0;
				end else begin
					r = pending_requests.pop_front();
					op              <= r.op;
					operand_years   <= r.years;
					operand_days    <= r.days;
					operand_hours   <= r.hours;
					operand_minutes <= r.minutes;
					operand_seconds <= r.seconds;
					op_valid        <= 1'b1;
					slot_busy = 1'b1;
					if (tx_burst_left <= 1) begin
						tx_burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2: tx_gap_left = 0;
							9:       tx_gap_left = $urandom_range(10, 30);
							default: tx_gap_left = $urandom_range(1, 6);
						endcase
					end else begin
						tx_burst_left--;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result-side stall pattern: free-flowing stretches, choppy stretches,
	// and stretches with occasional long stalls.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		bit stall_nxt;
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_run > 0) begin
			rx_stall_run--;
			stall_nxt = 1'b1;
		end else begin
			case (rx_mode)
				RX_FLOW:   stall_nxt = 1'b0;
				RX_CHOPPY: stall_nxt = ($urandom_range(0, 2) == 0);
				default: begin
					stall_nxt = ($urandom_range(0, 15) == 0);
					if (stall_nxt) rx_stall_run = $urandom_range(1, 20);
				end
			endcase
		end
		res_stall <= stall_nxt;
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge, predict for an accepted request and
	// check an accepted result against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		duration_snapshot_t want;
		if (arst_n) begin
			if (op_valid && !op_stall) begin
				expected_durations.push_back(step_duration(op, operand_years, operand_days,
					operand_hours, operand_minutes, operand_seconds));
				req_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				if (expected_durations.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0d: unexpected result, years %0d days %0d", cycle_count,
							now_years, now_days);
				end else begin
					want = expected_durations.pop_front();
					if (now_years !== want.years || now_days !== want.days ||
							now_hours !== want.hours || now_minutes !== want.minutes ||
							now_seconds !== want.seconds || total_seconds !== want.tsec ||
							total_days !== want.tday) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("%0d: mismatch exp y=%0d d=%0d %0d:%0d:%0d ts=%0d td=%0d",
								cycle_count, $signed(want.years), want.days, want.hours,
								want.minutes, want.seconds, $signed(want.tsec),
								$signed(want.tday));
							$display("%0d:          got y=%0d d=%0d %0d:%0d:%0d ts=%0d td=%0d",
								cycle_count, now_years, now_days, now_hours, now_minutes,
								now_seconds, total_seconds, total_days);
						end
					end
				end
			end
		end
	end

	// Watchdog: cycle counter with a generous bound on the whole run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL mixed_radix_duration_accumulator_top");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: build the request list, release reset, wait for the
	// traffic to finish and report.
	// ------------------------------------------------------------------
	initial begin
		// Directed corners
		queue_request(OP_NOP, 0, 0, 0, 0, 0);                   // unused op on reset value
		queue_request(OP_LOAD, 32'sh7fff_ffff, 364, 23, 59, 59); // largest held value
		queue_request(OP_ADD, 0, 0, 0, 0, 1);                   // full carry, years wrap
		queue_request(OP_SUB, 0, 0, 0, 0, 1);                   // full borrow back
		queue_request(OP_LOAD, 32'sh8000_0000, 0, 0, 0, 0);     // most negative years
		queue_request(OP_SUB, 0, 0, 0, 0, 1);                   // borrow wraps years
		queue_request(OP_ADD, 32'sh7fff_ffff, 364, 23, 59, 59); // largest operand
		queue_request(OP_LOAD, -1, 511, 31, 63, 63);            // out-of-range parts saturate
		queue_request(OP_ADD, 0, 365, 24, 60, 60);              // just above range on add
		queue_request(OP_SUB, 0, 511, 31, 63, 63);              // out of range on subtract
		queue_request(OP_NOP, 32'sh5555_5555, 300, 17, 42, 13); // unused op with busy operand
		queue_request(OP_LOAD, 0, 0, 0, 0, 0);
		queue_request(OP_SUB, 1, 0, 0, 0, 0);                   // go negative
		queue_request(OP_ADD, -1, 364, 23, 59, 59);
		queue_request(OP_LOAD, 32'shaaaa_aaaa, 256, 16, 32, 32);
		queue_request(OP_ADD, 32'sh5555_5555, 108, 15, 31, 31); // alternating bit patterns
		queue_request(OP_SUB, 32'sh8000_0000, 1, 1, 1, 1);
		queue_request(OP_LOAD, 0, 364, 0, 0, 0);
		queue_request(OP_ADD, 0, 1, 0, 0, 0);                   // day carry only
		queue_request(OP_SUB, 0, 0, 0, 1, 0);                   // borrow from minutes up
		queue_request(OP_ADD, 0, 0, 23, 59, 59);
		queue_request(OP_SUB, 0, 364, 23, 59, 59);

		// Random traffic; the sender drains the block at a few points
		for (int i = 0; i < RANDOM_COUNT; i++)
			queue_random_request(i == 0 || i == 600 || i == 1200);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || slot_busy || expected_durations.size() != 0)
			@(posedge clk);
		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_durations.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0) begin
			$display("PASS mixed_radix_duration_accumulator_top");
		end else begin
			$display("FAIL mixed_radix_duration_accumulator_top");
		end
		$finish;
	end

endmodule
